/* hdl/hjlp_pkg.sv */
// hjlp_pkg: shared constants, codes and types of the hash-join probe table
// used by the front, back, top level, checker and testbench; depends on nothing
`timescale 1ns / 1ps
package hjlp_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 1024;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned KEY_W = 63;
  localparam int unsigned ROW_W = 16;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  // home slot search: key padded to whole 16-bit digits, a multiply step and a reduce step per digit
  localparam int unsigned DIGIT_W = 16;
  localparam int unsigned KEY_PAD_W = 64;
  localparam int unsigned DIGITS = KEY_PAD_W / DIGIT_W;
  localparam int unsigned DCNT_W = $clog2(DIGITS);

  localparam logic [MODE_W-1:0] MODE_BUILD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PROBE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_MATCH     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOMATCH   = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd5;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_RED,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_INIT,
    B_IDLE,
    B_PROBE,
    B_CLEAR
  } back_state_e;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

/* hdl/hjlp_ram.sv */
// hjlp_ram: generic simple dual-port ram, one write and one registered read
// stands alone, no package needed
`timescale 1ns / 1ps
module hjlp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/hjlp_fifo.sv */
// hjlp_fifo: short queue between the front and back parts
// stands alone, no package needed
`timescale 1ns / 1ps
module hjlp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = buf_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/hjlp_front.sv */
// hjlp_front: takes items in and works out the home slot, key mod table size
// depends on hjlp_pkg; feeds hjlp_fifo
`timescale 1ns / 1ps
module hjlp_front #(
  parameter int unsigned TABLE_SLOTS = hjlp_pkg::TABLE_SLOTS_DEF,
  localparam int unsigned IW = $clog2(TABLE_SLOTS),
  localparam int unsigned EW = hjlp_pkg::MODE_W + hjlp_pkg::KEY_W + hjlp_pkg::ROW_W + IW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [hjlp_pkg::MODE_W-1:0]  mode_i,
  input  logic [hjlp_pkg::KEY_W-1:0]   key_i,
  input  logic [hjlp_pkg::ROW_W-1:0]   row_id_i,
  input  hjlp_pkg::back_stat_t         back_stat_i,
  output logic                         q_push_o,
  output logic [EW-1:0]                q_data_o,
  input  logic                         q_full_i
);

  localparam int unsigned VW = 2 * hjlp_pkg::DIGIT_W;
  localparam int unsigned PRW = 2 * VW + 1;
  localparam int unsigned SHIFT = VW + IW;
  localparam logic [VW:0] RECIP = (VW + 1)'((64'd1 << SHIFT) / 64'(TABLE_SLOTS));
  localparam logic [VW-1:0] SLOTS_V = VW'(TABLE_SLOTS);

  hjlp_pkg::front_state_e state_q, state_d;
  logic [hjlp_pkg::DCNT_W-1:0]    dcnt_q, dcnt_d;
  logic [hjlp_pkg::KEY_PAD_W-1:0] sh_q, sh_d;
  logic [IW-1:0]                  rem_q, rem_d, rem_step;
  logic [VW-1:0]                  acc, part;
  logic [PRW-1:0]                 prod_q, prod_d;
  logic [hjlp_pkg::DIGIT_W:0]     q_est;
  logic [hjlp_pkg::MODE_W-1:0]    mode_q;
  logic [hjlp_pkg::KEY_W-1:0]     key_q;
  logic [hjlp_pkg::ROW_W-1:0]     row_q;
  logic                           take;

  assign full_o   = (state_q != hjlp_pkg::F_IDLE) || back_stat_i.init_busy;
  assign take     = push_i && !full_o;
  assign q_data_o = {mode_q, key_q, row_q, rem_q};

  // running remainder shifted up by one digit plus the next key digit
  assign acc    = {(VW - hjlp_pkg::DIGIT_W)'(rem_q),
                   sh_q[hjlp_pkg::KEY_PAD_W-1 -: hjlp_pkg::DIGIT_W]};
  assign prod_d = PRW'(acc) * PRW'(RECIP);
  // quotient estimate is exact or one low, so one correction step
  assign q_est  = prod_q[SHIFT +: hjlp_pkg::DIGIT_W + 1];

  always_comb begin
    part = acc - (VW'(q_est) * SLOTS_V);
    if (part >= SLOTS_V) begin
      part = part - SLOTS_V;
    end
    rem_step = part[IW-1:0];
  end

  always_comb begin
    state_d  = state_q;
    dcnt_d   = dcnt_q;
    sh_d     = sh_q;
    rem_d    = rem_q;
    q_push_o = 1'b0;
    case (state_q)
      hjlp_pkg::F_IDLE: begin
        if (take) begin
          sh_d    = {1'b0, key_i};
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = hjlp_pkg::F_MUL;
        end
      end
      hjlp_pkg::F_MUL: begin
        state_d = hjlp_pkg::F_RED;
      end
      hjlp_pkg::F_RED: begin
        rem_d  = rem_step;
        sh_d   = sh_q << hjlp_pkg::DIGIT_W;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == hjlp_pkg::DCNT_W'(hjlp_pkg::DIGITS - 1)) begin
          state_d = hjlp_pkg::F_PUSH;
        end else begin
          state_d = hjlp_pkg::F_MUL;
        end
      end
      hjlp_pkg::F_PUSH: begin
        q_push_o = 1'b1;
        if (!q_full_i) begin
          state_d = hjlp_pkg::F_IDLE;
        end
      end
      default: state_d = hjlp_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hjlp_pkg::F_IDLE;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
    if (take) begin
      mode_q <= mode_i;
      key_q  <= key_i;
      row_q  <= row_id_i;
    end
  end

endmodule

/* hdl/hjlp_back.sv */
// hjlp_back: walks the probe chain in table memory, inserts, clears, counts
// depends on hjlp_pkg and hjlp_ram; fed by hjlp_fifo
`timescale 1ns / 1ps
module hjlp_back #(
  parameter int unsigned TABLE_SLOTS = hjlp_pkg::TABLE_SLOTS_DEF,
  localparam int unsigned IW = $clog2(TABLE_SLOTS),
  localparam int unsigned EW = hjlp_pkg::MODE_W + hjlp_pkg::KEY_W + hjlp_pkg::ROW_W + IW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  logic [EW-1:0]                 q_data_i,
  output logic                          q_pop_o,
  output hjlp_pkg::back_stat_t          back_stat_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [hjlp_pkg::STAT_W-1:0]   status_o,
  output logic [hjlp_pkg::ROW_W-1:0]    inner_row_o,
  output logic [hjlp_pkg::ROW_W-1:0]    outer_row_o,
  output logic [hjlp_pkg::TOTAL_W-1:0]  match_total_o
);

  localparam int unsigned WW = 1 + hjlp_pkg::KEY_W + hjlp_pkg::ROW_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SLOTS - 1);

  hjlp_pkg::back_state_e state_q, state_d;
  logic [IW-1:0]                 idx_q, idx_d, idx_next, cnt_q, cnt_d;
  logic [hjlp_pkg::MODE_W-1:0]   mode_q, mode_d, in_mode;
  logic [hjlp_pkg::KEY_W-1:0]    key_q, key_d, in_key;
  logic [hjlp_pkg::ROW_W-1:0]    row_q, row_d, in_row;
  logic [IW-1:0]                 in_home;
  logic [hjlp_pkg::TOTAL_W-1:0]  total_q, total_d;
  logic                          ov_q, ov_d;
  logic [hjlp_pkg::STAT_W-1:0]   st_q, st_d;
  logic [hjlp_pkg::ROW_W-1:0]    inner_q, inner_d, outer_q, outer_d;
  logic [hjlp_pkg::TOTAL_W-1:0]  otot_q, otot_d;
  logic                          we;
  logic [WW-1:0]                 wdata, rdata;
  logic                          s_used, hit, stop;

  assign {in_mode, in_key, in_row, in_home} = q_data_i;
  assign s_used   = rdata[WW-1];
  assign hit      = s_used && (rdata[WW-2 -: hjlp_pkg::KEY_W] == key_q);
  assign stop     = !s_used || hit;
  assign idx_next = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;

  assign back_stat_o.init_busy = (state_q == hjlp_pkg::B_INIT);
  assign empty_o       = !ov_q;
  assign status_o      = st_q;
  assign inner_row_o   = inner_q;
  assign outer_row_o   = outer_q;
  assign match_total_o = otot_q;

  hjlp_ram #(
    .WIDTH (WW),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .raddr_i (idx_d),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    mode_d  = mode_q;
    key_d   = key_q;
    row_d   = row_q;
    total_d = total_q;
    ov_d    = ov_q && !pop_i;
    st_d    = st_q;
    inner_d = inner_q;
    outer_d = outer_q;
    otot_d  = otot_q;
    q_pop_o = 1'b0;
    we      = 1'b0;
    wdata   = '0;
    case (state_q)
      hjlp_pkg::B_INIT, hjlp_pkg::B_CLEAR: begin
        we    = 1'b1;
        idx_d = idx_next;
        if (idx_q == LAST_SLOT) begin
          state_d = hjlp_pkg::B_IDLE;
          if (state_q == hjlp_pkg::B_CLEAR) begin
            ov_d    = 1'b1;
            st_d    = hjlp_pkg::ST_CLEARED;
            inner_d = '0;
            outer_d = row_q;
            otot_d  = total_q;
          end
        end
      end
      hjlp_pkg::B_IDLE: begin
        // one item in flight, started only once the result slot is free
        if (!q_empty_i && !ov_q) begin
          q_pop_o = 1'b1;
          mode_d  = in_mode;
          key_d   = in_key;
          row_d   = in_row;
          if (in_mode == hjlp_pkg::MODE_CLEAR) begin
            idx_d   = '0;
            total_d = '0;
            state_d = hjlp_pkg::B_CLEAR;
          end else if (in_mode == hjlp_pkg::MODE_BUILD || in_mode == hjlp_pkg::MODE_PROBE) begin
            idx_d   = in_home;
            cnt_d   = '0;
            state_d = hjlp_pkg::B_PROBE;
          end else begin
            ov_d    = 1'b1;
            st_d    = hjlp_pkg::ST_NOMATCH;
            inner_d = '0;
            outer_d = in_row;
            otot_d  = total_q;
          end
        end
      end
      hjlp_pkg::B_PROBE: begin
        // rdata holds the slot at idx_q
        if (stop || cnt_q == LAST_SLOT) begin
          state_d = hjlp_pkg::B_IDLE;
          ov_d    = 1'b1;
          inner_d = '0;
          outer_d = row_q;
          otot_d  = total_q;
          if (mode_q == hjlp_pkg::MODE_BUILD) begin
            if (!stop) begin
              st_d = hjlp_pkg::ST_FULL;
            end else if (s_used) begin
              st_d = hjlp_pkg::ST_DUPLICATE;
            end else begin
              we    = 1'b1;
              wdata = {1'b1, key_q, row_q};
              st_d  = hjlp_pkg::ST_INSERTED;
            end
          end else if (hit) begin
            st_d    = hjlp_pkg::ST_MATCH;
            inner_d = rdata[hjlp_pkg::ROW_W-1:0];
            if (total_q != hjlp_pkg::TOTAL_MAX) begin
              total_d = total_q + 1'b1;
            end
            otot_d = total_d;
          end else begin
            st_d = hjlp_pkg::ST_NOMATCH;
          end
        end else begin
          idx_d = idx_next;
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = hjlp_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hjlp_pkg::B_INIT;
      idx_q   <= '0;
      cnt_q   <= '0;
      total_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    key_q   <= key_d;
    row_q   <= row_d;
    st_q    <= st_d;
    inner_q <= inner_d;
    outer_q <= outer_d;
    otot_q  <= otot_d;
  end

endmodule

/* hdl/hash_join_linear_probe_table.sv */
// channel  | handshake          | fields
// input    | push_i / full_o    | mode_i, key_i, row_id_i
// result   | pop_i / empty_o    | status_o, inner_row_o, outer_row_o, match_total_o
//
// build and probe items pass through the front (home slot, a multiply and a reduce step a 16-bit key digit),
// overlapped with the back, which walks the probe chain (one ram read a slot).
// a clear item is done in the back, one slot cleared a cycle.
// after reset full_o stays high while the table is cleared.
// a waiting result holds the back; up to two items queue between front and back.
//
// top level: front, queue, back; depends on hjlp_pkg and all hjlp_* modules
`timescale 1ns / 1ps
module hash_join_linear_probe_table #(
  parameter int unsigned TABLE_SLOTS = hjlp_pkg::TABLE_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [hjlp_pkg::MODE_W-1:0]   mode_i,
  input  logic [hjlp_pkg::KEY_W-1:0]    key_i,
  input  logic [hjlp_pkg::ROW_W-1:0]    row_id_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [hjlp_pkg::STAT_W-1:0]   status_o,
  output logic [hjlp_pkg::ROW_W-1:0]    inner_row_o,
  output logic [hjlp_pkg::ROW_W-1:0]    outer_row_o,
  output logic [hjlp_pkg::TOTAL_W-1:0]  match_total_o
);

  localparam int unsigned IW = $clog2(TABLE_SLOTS);
  localparam int unsigned EW = hjlp_pkg::MODE_W + hjlp_pkg::KEY_W + hjlp_pkg::ROW_W + IW;

  hjlp_pkg::back_stat_t back_stat;
  logic          q_push, q_full, q_pop, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;

  hjlp_front #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .mode_i      (mode_i),
    .key_i       (key_i),
    .row_id_i    (row_id_i),
    .back_stat_i (back_stat),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .q_full_i    (q_full)
  );

  hjlp_fifo #(
    .WIDTH (EW),
    .DEPTH (hjlp_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  hjlp_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .back_stat_o   (back_stat),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .status_o      (status_o),
    .inner_row_o   (inner_row_o),
    .outer_row_o   (outer_row_o),
    .match_total_o (match_total_o)
  );

endmodule

/* hdl/hjlp_checker.sv */
// hjlp_checker: port-level assertions on the result side of the table
// depends on hjlp_pkg; bound to hash_join_linear_probe_table
`timescale 1ns / 1ps
module hjlp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          empty_o,
  input logic                          pop_i,
  input logic [hjlp_pkg::STAT_W-1:0]   status_o,
  input logic [hjlp_pkg::ROW_W-1:0]    inner_row_o,
  input logic [hjlp_pkg::ROW_W-1:0]    outer_row_o,
  input logic [hjlp_pkg::TOTAL_W-1:0]  match_total_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> !empty_o)
    else $error("result dropped before pop");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> ($stable(status_o) && $stable(outer_row_o)
                              && $stable(match_total_o)))
    else $error("waiting result changed");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (status_o <= hjlp_pkg::ST_CLEARED))
    else $error("status out of range");

  a_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o != hjlp_pkg::ST_MATCH) |-> (inner_row_o == '0))
    else $error("inner row set without match");

  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o == hjlp_pkg::ST_CLEARED) |-> (match_total_o == '0))
    else $error("match total not zero after clear");

endmodule

bind hash_join_linear_probe_table hjlp_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty_o       (empty_o),
  .pop_i         (pop_i),
  .status_o      (status_o),
  .inner_row_o   (inner_row_o),
  .outer_row_o   (outer_row_o),
  .match_total_o (match_total_o)
);

/* bench/tb_hash_join_linear_probe_table.sv */
// testbench for hash_join_linear_probe_table: directed and random build, probe, clear and unused-mode items
// checked against an in-bench open-addressing table model; depends on hjlp_pkg
`timescale 1ns / 1ps
module tb_hash_join_linear_probe_table;

  localparam int unsigned SLOTS = hjlp_pkg::TABLE_SLOTS_DEF;

  typedef struct packed {
    logic [hjlp_pkg::STAT_W-1:0]  status;
    logic [hjlp_pkg::ROW_W-1:0]   inner_row;
    logic [hjlp_pkg::ROW_W-1:0]   echo_row;
    logic [hjlp_pkg::TOTAL_W-1:0] match_total;
  } join_res_t;

  class join_table_sb;
    bit                           used [SLOTS];
    logic [hjlp_pkg::KEY_W-1:0]   keys [SLOTS];
    logic [hjlp_pkg::ROW_W-1:0]   rows [SLOTS];
    logic [hjlp_pkg::TOTAL_W-1:0] match_cnt;
    join_res_t                    pending [$];
    int                           errors;

    function new();
      foreach (used[i]) used[i] = 0;
      match_cnt = '0;
      errors = 0;
    endfunction

    // returns 1 if the chain stopped at a free slot or the key
    function bit walk(logic [hjlp_pkg::KEY_W-1:0] k, output int unsigned at);
      int unsigned idx;
      idx = k % SLOTS;
      at = 0;
      for (int n = 0; n < SLOTS; n++) begin
        if (!used[idx] || keys[idx] == k) begin
          at = idx;
          return 1;
        end
        idx = (idx + 1) % SLOTS;
      end
      return 0;
    endfunction

    function void note_item(logic [hjlp_pkg::MODE_W-1:0] m, logic [hjlp_pkg::KEY_W-1:0] k,
                            logic [hjlp_pkg::ROW_W-1:0] r);
      join_res_t e;
      int unsigned at;
      bit hit;
      e.status = hjlp_pkg::ST_NOMATCH;
      e.inner_row = '0;
      e.echo_row = r;
      if (m == hjlp_pkg::MODE_BUILD) begin
        hit = walk(k, at);
        if (!hit) e.status = hjlp_pkg::ST_FULL;
        else if (used[at]) e.status = hjlp_pkg::ST_DUPLICATE;
        else begin
          used[at] = 1;
          keys[at] = k;
          rows[at] = r;
          e.status = hjlp_pkg::ST_INSERTED;
        end
      end else if (m == hjlp_pkg::MODE_PROBE) begin
        hit = walk(k, at);
        if (hit && used[at]) begin
          e.status = hjlp_pkg::ST_MATCH;
          e.inner_row = rows[at];
          if (match_cnt != hjlp_pkg::TOTAL_MAX) match_cnt++;
        end
      end else if (m == hjlp_pkg::MODE_CLEAR) begin
        foreach (used[i]) used[i] = 0;
        match_cnt = '0;
        e.status = hjlp_pkg::ST_CLEARED;
      end
      e.match_total = match_cnt;
      pending.push_back(e);
    endfunction

    function void check_result(join_res_t got);
      join_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.inner_row !== e.inner_row) begin
        $display("%0t: inner_row expected %0h actual %0h", $time, e.inner_row, got.inner_row);
        errors++;
      end
      if (got.echo_row !== e.echo_row) begin
        $display("%0t: outer row expected %0h actual %0h", $time, e.echo_row, got.echo_row);
        errors++;
      end
      if (got.match_total !== e.match_total) begin
        $display("%0t: match_total expected %0d actual %0d", $time, e.match_total,
                 got.match_total);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i = 0;
  logic                         rst_ni = 0;
  logic                         push_i = 0;
  logic                         pop_i = 0;
  logic [hjlp_pkg::MODE_W-1:0]  mode_i = '0;
  logic [hjlp_pkg::KEY_W-1:0]   key_i = '0;
  logic [hjlp_pkg::ROW_W-1:0]   row_id_i = '0;
  logic                         full_o, empty_o;
  logic [hjlp_pkg::STAT_W-1:0]  status_o;
  logic [hjlp_pkg::ROW_W-1:0]   inner_row_o, outer_row_o;
  logic [hjlp_pkg::TOTAL_W-1:0] match_total_o;

  join_table_sb sb = new();
  bit           sending_done = 0;
  bit           calm = 0;       // no idling on either side
  int           hold_cycles = 0;
  logic [hjlp_pkg::KEY_W-1:0] recent_keys [$];

  hash_join_linear_probe_table dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // one item; random gaps unless calm
  task automatic send_item(logic [hjlp_pkg::MODE_W-1:0] m, logic [hjlp_pkg::KEY_W-1:0] k,
                           logic [hjlp_pkg::ROW_W-1:0] r);
    while (!calm && $urandom_range(99) < 31) begin
      push_i <= 0;
      @(posedge clk_i);
    end
    push_i <= 1;
    mode_i <= m;
    key_i <= k;
    row_id_i <= r;
    do @(posedge clk_i); while (full_o);
    sb.note_item(m, k, r);
    if (m == hjlp_pkg::MODE_BUILD) recent_keys.push_back(k);
    if (recent_keys.size() > 64) void'(recent_keys.pop_front());
  endtask

  function automatic logic [hjlp_pkg::KEY_W-1:0] rand_key();
    logic [hjlp_pkg::KEY_W-1:0] k;
    int sel;
    sel = $urandom_range(9);
    k = hjlp_pkg::KEY_W'({$urandom, $urandom});
    if (sel < 4 && recent_keys.size() > 0)
      k = recent_keys[$urandom_range(recent_keys.size() - 1)];
    else if (sel < 7)   // colliding home slots
      k = hjlp_pkg::KEY_W'($urandom_range(40) * SLOTS + $urandom_range(7));
    return k;
  endfunction

  task automatic clear_table();
    send_item(hjlp_pkg::MODE_CLEAR, rand_key(), 16'($urandom));
    recent_keys.delete();
  endtask

  // receiver
  initial begin
    join_res_t got;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        pop_i <= 0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      pop_i <= calm || ($urandom_range(99) >= 31);
      @(posedge clk_i);
      if (pop_i && !empty_o) begin
        got.status = status_o;
        got.inner_row = inner_row_o;
        got.echo_row = outer_row_o;
        got.match_total = match_total_o;
        sb.check_result(got);
      end
    end
  end

  initial begin
    logic [hjlp_pkg::KEY_W-1:0] k;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: field extremes, each mode, duplicate, miss, unused mode
    send_item(hjlp_pkg::MODE_PROBE, '0, '0);
    send_item(hjlp_pkg::MODE_BUILD, '0, '1);
    send_item(hjlp_pkg::MODE_BUILD, '1, 16'h0000);
    send_item(hjlp_pkg::MODE_BUILD, '0, 16'h1234);
    send_item(hjlp_pkg::MODE_PROBE, '1, 16'hffff);
    send_item(hjlp_pkg::MODE_PROBE, '0, 16'h5555);
    send_item(hjlp_pkg::MODE_PROBE, 63'd1024, 16'haaaa);
    send_item(hjlp_pkg::MODE_BUILD, 63'd1024, 16'h00ff);
    send_item(hjlp_pkg::MODE_BUILD, 63'd2048, 16'hff00);
    send_item(hjlp_pkg::MODE_PROBE, 63'd2048, 16'h0f0f);
    send_item(hjlp_pkg::MODE_SPARE, '1, 16'hf0f0);
    send_item(hjlp_pkg::MODE_PROBE, 63'h2aaa_aaaa_aaaa_aaaa, 16'h0001);
    clear_table();
    send_item(hjlp_pkg::MODE_PROBE, '0, 16'h0002);
    // long receiver hold-off while items keep coming
    hold_cycles = 300;
    for (int i = 0; i < 580; i++) begin
      if (i == 300) calm = 1;
      if (i == 400) calm = 0;
      if ($urandom_range(99) < 2) clear_table();
      else begin
        k = rand_key();
        send_item($urandom_range(99) < 50 ? hjlp_pkg::MODE_BUILD :
                  ($urandom_range(99) < 95 ? hjlp_pkg::MODE_PROBE : hjlp_pkg::MODE_SPARE),
                  k, 16'($urandom));
      end
    end
    push_i <= 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    wait (sb.pending.size() == 0);
    repeat (2 * SLOTS + 100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_hash_join_linear_probe_table: clean");
    else
      $display("tb_hash_join_linear_probe_table: errors");
    $finish;
  end

  initial begin
    #60ms;
    $display("tb_hash_join_linear_probe_table: errors");
    $finish;
  end
endmodule
